@@ sv/wav_hdr_pkg.sv @@
// Shared types, codes and helpers for the WAV header parser.
package wav_hdr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned SKIP_W  = 33;
	localparam int unsigned OUT_DATA_W = 192;
	localparam int unsigned OUT_USER_W = 4;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [IDX_W-1:0] FMT_CAPTURE_BYTES = IDX_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE    = 2'd0,
		CMD_EOF     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_RIFF    = 3'd1,
		ST_NOT_WAVE    = 3'd2,
		ST_TRUNC_HDR   = 3'd3,
		ST_TRUNC_FMT   = 3'd4,
		ST_NOT_PCM     = 3'd5,
		ST_BAD_BITS    = 3'd6,
		ST_BAD_CHANNEL = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2
	} chunk_kind_t;

	typedef struct packed {
		logic [31:0] data_start;
		logic [31:0] data_length;
		logic [15:0] sample_bits;
		logic [15:0] frame_bytes;
		logic [31:0] bytes_per_sec;
		logic [31:0] samples_per_sec;
		logic [15:0] channel_count;
		logic [15:0] format_tag;
	} fmt_fields_t;

	function automatic status_t final_status(input logic [15:0] fmt_tag,
			input logic [15:0] bits, input logic [15:0] chans);
		status_t st;
		st = ST_OK;
		if (fmt_tag != 16'd1) begin
			st = ST_NOT_PCM;
		end else if (bits != 16'd8 && bits != 16'd16) begin
			st = ST_BAD_BITS;
		end else if (chans != 16'd1 && chans != 16'd2) begin
			st = ST_BAD_CHANNEL;
		end
		return st;
	endfunction

endpackage

@@ sv/wav_header_parser_core.sv @@
// Byte-serial RIFF/WAVE PCM header parser with stream input and result output.
// The result is registered: its causing transaction passes the input register stage, then the output register.
// Throughput: one input transaction per cycle; set by the single input register stage.
// The input stalls only while a pending result is not taken and the staged item is held.
// Reset (arst_n low) clears the parse state, held fields and both valid flags at once.
module wav_header_parser_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [wav_hdr_pkg::BYTE_W-1:0] s_axis_tdata,     // file_byte
	input  logic [wav_hdr_pkg::CMD_W-1:0] s_axis_tuser,      // cmd
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// format_tag, channel_count, samples_per_sec, bytes_per_sec, frame_bytes,
	// sample_bits, data_length, data_start
	output logic [wav_hdr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [wav_hdr_pkg::OUT_USER_W-1:0] m_axis_tuser  // status, sample_kind
);
	import wav_hdr_pkg::*;

	typedef enum logic [3:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_SKIP, PH_DONE
	} phase_t;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] byte_s1;

	phase_t            phase_q, phase_n;
	logic [IDX_W-1:0]  idx_q, idx_n, idx_inc;
	logic [31:0]       shift_q, shift_n, shift_inc;
	chunk_kind_t       kind_q, kind_n;
	logic [31:0]       size_q, size_n;
	logic [SKIP_W-1:0] skip_q, skip_n;
	logic              fmt_found_q, fmt_found_n;
	logic              data_found_q, data_found_n;
	fmt_fields_t       held_q, held_n;
	logic [31:0]       bytes_q, bytes_n, bytes_inc;

	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	logic    out_free, proc, emit;
	status_t st;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign idx_inc   = idx_q + IDX_W'(1);
	assign shift_inc = {byte_s1, shift_q[31:8]};
	assign bytes_inc = (bytes_q == 32'hFFFF_FFFF) ? bytes_q : bytes_q + 32'd1;

	always_comb begin
		phase_n      = phase_q;
		idx_n        = idx_q;
		shift_n      = shift_q;
		kind_n       = kind_q;
		size_n       = size_q;
		skip_n       = skip_q;
		fmt_found_n  = fmt_found_q;
		data_found_n = data_found_q;
		held_n       = held_q;
		bytes_n      = bytes_q;
		emit         = 1'b0;
		st           = ST_OK;
		if (proc) begin
			case (cmd_s1)
				CMD_RESTART: begin
					phase_n      = PH_RIFF;
					idx_n        = '0;
					shift_n      = '0;
					kind_n       = KIND_OTHER;
					size_n       = '0;
					skip_n       = '0;
					fmt_found_n  = 1'b0;
					data_found_n = 1'b0;
					held_n       = '0;
					bytes_n      = '0;
				end
				CMD_EOF: begin
					if (phase_q != PH_DONE) begin
						emit    = 1'b1;
						st      = (phase_q == PH_FMT) ? ST_TRUNC_FMT : ST_TRUNC_HDR;
						phase_n = PH_DONE;
					end
				end
				CMD_BYTE: begin
					if (phase_q == PH_SKIP) begin
						bytes_n = bytes_inc;
						skip_n  = skip_q - SKIP_W'(1);
						if (skip_n == '0) begin
							phase_n = PH_CID;
						end
					end else if (phase_q != PH_DONE) begin
						bytes_n = bytes_inc;
						shift_n = shift_inc;
						idx_n   = idx_inc;
						case (phase_q)
							PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID: begin
								if (idx_inc >= IDX_W'(4)) begin
									idx_n = '0;
									case (phase_q)
										PH_RIFF: begin
											if (shift_inc != TAG_RIFF) begin
												emit    = 1'b1;
												st      = ST_NOT_RIFF;
												phase_n = PH_DONE;
											end else begin
												phase_n = PH_RSIZE;
											end
										end
										PH_RSIZE: phase_n = PH_WAVE;
										PH_WAVE: begin
											if (shift_inc != TAG_WAVE) begin
												emit    = 1'b1;
												st      = ST_NOT_WAVE;
												phase_n = PH_DONE;
											end else begin
												phase_n = PH_CID;
											end
										end
										default: begin
											if (shift_inc == TAG_FMT) begin
												kind_n = KIND_FMT;
											end else if (shift_inc == TAG_DATA) begin
												kind_n = KIND_DATA;
											end else begin
												kind_n = KIND_OTHER;
											end
											phase_n = PH_CSIZE;
										end
									endcase
								end
							end
							PH_CSIZE: begin
								if (idx_inc >= IDX_W'(4)) begin
									idx_n  = '0;
									size_n = shift_inc;
									if (kind_q == KIND_FMT) begin
										phase_n = PH_FMT;
									end else begin
										if (kind_q == KIND_DATA) begin
											held_n.data_length = shift_inc;
											held_n.data_start  = bytes_inc;
											data_found_n       = 1'b1;
										end
										if (kind_q == KIND_DATA && fmt_found_q) begin
											emit    = 1'b1;
											st      = final_status(held_n.format_tag,
													held_n.sample_bits, held_n.channel_count);
											phase_n = PH_DONE;
										end else begin
											skip_n  = {1'b0, shift_inc} + SKIP_W'(shift_inc[0]);
											phase_n = (skip_n == '0) ? PH_CID : PH_SKIP;
										end
									end
								end
							end
							PH_FMT: begin
								case (idx_inc)
									IDX_W'(2):  held_n.format_tag      = shift_inc[31:16];
									IDX_W'(4):  held_n.channel_count   = shift_inc[31:16];
									IDX_W'(8):  held_n.samples_per_sec = shift_inc;
									IDX_W'(12): held_n.bytes_per_sec   = shift_inc;
									IDX_W'(14): held_n.frame_bytes     = shift_inc[31:16];
									IDX_W'(16): held_n.sample_bits     = shift_inc[31:16];
									default: ;
								endcase
								if (idx_inc >= FMT_CAPTURE_BYTES) begin
									idx_n       = '0;
									fmt_found_n = 1'b1;
									if (data_found_q) begin
										emit    = 1'b1;
										st      = final_status(held_n.format_tag,
												held_n.sample_bits, held_n.channel_count);
										phase_n = PH_DONE;
									end else begin
										if (size_q > 32'd16) begin
											skip_n = {1'b0, size_q - 32'd16} + SKIP_W'(size_q[0]);
										end else begin
											skip_n = SKIP_W'(size_q[0]);
										end
										phase_n = (skip_n == '0) ? PH_CID : PH_SKIP;
									end
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RIFF;
			idx_q        <= '0;
			shift_q      <= '0;
			kind_q       <= KIND_OTHER;
			size_q       <= '0;
			skip_q       <= '0;
			fmt_found_q  <= 1'b0;
			data_found_q <= 1'b0;
			held_q       <= '0;
			bytes_q      <= '0;
		end else begin
			phase_q      <= phase_n;
			idx_q        <= idx_n;
			shift_q      <= shift_n;
			kind_q       <= kind_n;
			size_q       <= size_n;
			skip_q       <= skip_n;
			fmt_found_q  <= fmt_found_n;
			data_found_q <= data_found_n;
			held_q       <= held_n;
			bytes_q      <= bytes_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_data_q <= held_n;
			out_user_q <= {(st == ST_OK && held_n.sample_bits == 16'd16), st};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skip phase with zero count");

	a_fmt_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FMT |-> idx_q < FMT_CAPTURE_BYTES)
		else $error("fmt capture index out of range");

	a_field_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RIFF || phase_q == PH_RSIZE || phase_q == PH_WAVE ||
		 phase_q == PH_CID || phase_q == PH_CSIZE) |-> idx_q < IDX_W'(4))
		else $error("tag or size index out of range");

	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> phase_q == PH_DONE)
		else $error("result raised without parser stopping");

	a_ok_is_pcm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_user_q[2:0] == ST_OK) |-> out_data_q[15:0] == 16'd1)
		else $error("ok status with non-PCM format");
`endif

endmodule
